// ----- rtl/rmt_pkg.sv -----
// rmt_pkg: shared types and constants for the running mode block
// no dependencies
package rmt_pkg;
  localparam int ENTRIES = 256;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_REPORT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_OVF    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_WAIT, S_UPDATE, S_DIV, S_RSCAN, S_RWAIT, S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [95:0] mag;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] value;
  } in_word_t;

  typedef struct packed {
    logic [63:0] mode_value;
    logic [31:0] mode_count;
    logic        is_empty;
    status_t     status;
  } out_word_t;
endpackage

// ----- rtl/rmt_if.sv -----
// rmt_if: valid/ready channel carrying one word of a given payload type
// depends on nothing
interface rmt_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/running_mode_with_tiebreak.sv -----
// running_mode_with_tiebreak: top level, sequencer, table and tie-break compare
// depends on rmt_pkg, rmt_if, rmt_ram, rmt_div
//
// usage:
//   in  channel carries op and value; out channel carries mode_value,
//   mode_count, is_empty and status. one result word per input word.
//   add and remove scan every slot through the key/count rams, one slot a
//   cycle, since the scan goes through one ram read port. report runs the
//   bit-serial divider for the average, then scans all slots again.
//   clear goes straight to the done state.
//   input ready is low while a word is in work; the result is held in an
//   output register until taken, and the next word is accepted only after.
//   reset (rst, synchronous) empties the table: the valid bits, total count
//   and running sum clear at once; ram contents need no clearing.
module running_mode_with_tiebreak import rmt_pkg::*; (
  input logic clk,
  input logic rst,
  rmt_if.sink   in,
  rmt_if.source out
);
  state_t state, state_next;

  logic [ENTRIES-1:0] used;
  logic [31:0] total_count;
  logic [95:0] running_sum;

  op_t         op;
  logic [63:0] val;
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] ridx;       // slot the ram read data belongs to
  logic        rvalid;
  logic        found, free_ok;
  logic [IDX_W-1:0] hit_slot, free_slot;
  logic [31:0] hit_cnt;

  logic        ram_we;
  logic [IDX_W-1:0] ram_addr;
  logic [63:0] key_wdata, key_rd;
  logic [31:0] cnt_wdata, cnt_rd;

  logic [63:0] avg;
  logic        div_done;
  div_req_t    dreq;

  logic        have;
  logic [63:0] best, bestd;
  logic [31:0] bestc;

  logic [63:0] res_value;
  logic [31:0] res_count;
  status_t     res_status;
  logic        out_valid;

  rmt_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_key (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(key_wdata), .rdata(key_rd));
  rmt_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_cnt (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(cnt_wdata), .rdata(cnt_rd));
  rmt_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(div_done), .avg_biased(avg));

  assign in.ready  = (state == S_IDLE) && !out_valid;
  assign out.valid = out_valid;
  assign out.data.mode_value = res_value;
  assign out.data.mode_count = res_count;
  assign out.data.is_empty   = (total_count == 32'd0);
  assign out.data.status     = res_status;

  logic scan_end;
  assign scan_end = idx[IDX_W:0] == CNT_W'(ENTRIES);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in.valid && in.ready) begin
          case (in.data.op)
            OP_CLEAR:  state_next = S_DONE;
            OP_REPORT: state_next = S_DIV;
            default:   state_next = S_SCAN;
          endcase
        end
      end
      S_SCAN:      if (scan_end) state_next = S_SCAN_WAIT;
      S_SCAN_WAIT: state_next = S_UPDATE;
      S_UPDATE:    state_next = S_DONE;
      S_DIV:       if (div_done) state_next = S_RSCAN;
      S_RSCAN:     if (scan_end) state_next = S_RWAIT;
      S_RWAIT:     state_next = S_DONE;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // ram control and divider request
  logic upd_write;
  always_comb begin
    upd_write = 1'b0;
    ram_addr  = idx[IDX_W-1:0];
    key_wdata = val;
    cnt_wdata = 32'd1;
    if (state == S_UPDATE && total_count != 32'hFFFF_FFFF && op == OP_ADD) begin
      if (found) begin
        upd_write = 1'b1;
        ram_addr  = hit_slot;
        cnt_wdata = hit_cnt + 32'd1;
      end else if (free_ok) begin
        upd_write = 1'b1;
        ram_addr  = free_slot;
      end
    end else if (state == S_UPDATE && op == OP_REMOVE && found) begin
      upd_write = 1'b1;
      ram_addr  = hit_slot;
      cnt_wdata = hit_cnt - 32'd1;
    end
    ram_we = upd_write;
    dreq.start   = (state == S_IDLE) && in.valid && in.ready && in.data.op == OP_REPORT;
    dreq.neg     = running_sum[95];
    dreq.mag     = running_sum[95] ? (96'd0 - running_sum) : running_sum;
    dreq.divisor = total_count;
  end

  // tie-break compare on one slot
  logic [63:0] kd, ak, ab;
  logic        take;
  always_comb begin
    kd = (key_rd ^ 64'h8000_0000_0000_0000) > avg ?
         (key_rd ^ 64'h8000_0000_0000_0000) - avg :
         avg - (key_rd ^ 64'h8000_0000_0000_0000);
    ak = key_rd[63] ? 64'd0 - key_rd : key_rd;
    ab = best[63] ? 64'd0 - best : best;
    take = !have || cnt_rd > bestc ||
           (cnt_rd == bestc && (kd < bestd || (kd == bestd && ak < ab)));
  end

  logic [95:0] sext;
  assign sext = {{32{val[63]}}, val};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      used        <= '0;
      total_count <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
      rvalid      <= 1'b0;
    end else begin
      state  <= state_next;
      rvalid <= (state == S_SCAN || state == S_RSCAN) && !scan_end;
      ridx   <= idx[IDX_W-1:0];
      if (out_valid && out.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          op  <= op_t'(in.data.op);
          val <= in.data.value;
          idx <= '0;
          found <= 1'b0;
          free_ok <= 1'b0;
          have <= 1'b0;
          // the held result stays until a new word comes in
          if (in.valid && in.ready) begin
            res_value <= '0;
            res_count <= '0;
            res_status <= ST_OK;
          end
          if (in.valid && in.ready && in.data.op == OP_CLEAR) begin
            used <= '0;
            total_count <= '0;
            running_sum <= '0;
          end
        end
        S_SCAN, S_SCAN_WAIT: begin
          if (!scan_end) idx <= idx + CNT_W'(1);
          if (rvalid) begin
            if (used[ridx] && key_rd == val && !found) begin
              found <= 1'b1;
              hit_slot <= ridx;
              hit_cnt <= cnt_rd;
            end
          end
          if (state == S_SCAN && !scan_end && !used[idx[IDX_W-1:0]] && !free_ok) begin
            free_ok <= 1'b1;
            free_slot <= idx[IDX_W-1:0];
          end
        end
        S_UPDATE: begin
          if (op == OP_ADD) begin
            if (total_count == 32'hFFFF_FFFF) res_status <= ST_OVF;
            else if (found || free_ok) begin
              if (!found) used[free_slot] <= 1'b1;
              total_count <= total_count + 32'd1;
              running_sum <= running_sum + sext;
            end else res_status <= ST_FULL;
          end else begin
            if (!found) res_status <= ST_ABSENT;
            else begin
              if (hit_cnt == 32'd1) used[hit_slot] <= 1'b0;
              total_count <= total_count - 32'd1;
              running_sum <= running_sum - sext;
            end
          end
        end
        S_RSCAN, S_RWAIT: begin
          if (!scan_end) idx <= idx + CNT_W'(1);
          if (rvalid && used[ridx] && take) begin
            have  <= 1'b1;
            best  <= key_rd;
            bestd <= kd;
            if (!have || cnt_rd > bestc) bestc <= cnt_rd;
          end
          if (state == S_RWAIT) begin
            res_value <= (rvalid && used[ridx] && take) ? key_rd :
                         (have ? best : 64'd0);
            res_count <= (rvalid && used[ridx] && take && (!have || cnt_rd > bestc)) ?
                         cnt_rd : (have ? bestc : 32'd0);
          end
        end
        S_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

// ----- rtl/rmt_ram.sv -----
// rmt_ram: generic single-port ram with registered read
// no dependencies
module rmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/rmt_div.sv -----
// rmt_div: restoring divider, one quotient bit per cycle, truncated signed average
// depends on rmt_pkg
module rmt_div import rmt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [63:0] avg_biased
);
  logic [95:0] quo;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic [63:0] mag;

  always_comb begin
    trial = {rem[31:0], quo[95]} - {1'b0, dvs};
    mag = quo[63:0];
    avg_biased = (neg ? (64'd0 - mag) : mag) ^ 64'h8000_0000_0000_0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.mag;
        rem  <= '0;
        dvs  <= req.divisor;
        neg  <= req.neg;
        cnt  <= 7'd0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[94:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[95]};
          quo <= {quo[94:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd95) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for running_mode_with_tiebreak, with a directed table,
// random op streams, a table-fill phase and random stalls on both channels
// depends on rmt_pkg, rmt_if and the running_mode_with_tiebreak rtl
module tb_top import rmt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_VAL  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_VAL  = 64'h8000_0000_0000_0000;
  localparam int RANDOM_ITEMS = 1080;
  localparam int QUIET_TAIL   = 150;

  typedef struct packed {
    op_t         op;
    logic [63:0] value;
    logic        typed;
    out_word_t   res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  rmt_if #(.T(in_word_t))  in_ch(clk);
  rmt_if #(.T(out_word_t)) out_ch(clk);

  running_mode_with_tiebreak dut (
    .clk(clk),
    .rst(rst),
    .in(in_ch),
    .out(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the frequency table
  logic [63:0] key_mem [ENTRIES];
  logic [31:0] cnt_mem [ENTRIES];
  bit          used_mem[ENTRIES];
  logic [31:0] held_total;
  logic [95:0] held_sum;

  out_word_t mode_q[$];
  int        errors = 0;
  int        words_sent = 0;
  int        reports_seen = 0;
  int        fulls_seen = 0;
  int        absents_seen = 0;
  bit        quiet = 1'b0;
  logic [63:0] hot_vals[8];

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic out_word_t compute_mode(in_word_t w);
    out_word_t   r;
    int          slot;
    int          free_slot;
    bit          have;
    bit          neg;
    logic [95:0] mag;
    logic [95:0] quo;
    logic [63:0] m64;
    logic [63:0] avg_b;
    logic [63:0] d;
    logic [63:0] best_d;
    logic [63:0] best_k;
    logic [31:0] best_c;
    r = '0;
    r.status = ST_OK;
    slot = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (used_mem[i] && key_mem[i] == w.value && slot < 0) slot = i;
      if (!used_mem[i] && free_slot < 0) free_slot = i;
    end
    case (w.op)
      OP_ADD: begin
        if (held_total == 32'hFFFF_FFFF) begin
          r.status = ST_OVF;
        end else if (slot >= 0) begin
          cnt_mem[slot] = cnt_mem[slot] + 1;
          held_total = held_total + 1;
          held_sum = held_sum + {{32{w.value[63]}}, w.value};
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          used_mem[free_slot] = 1'b1;
          key_mem[free_slot] = w.value;
          cnt_mem[free_slot] = 32'd1;
          held_total = held_total + 1;
          held_sum = held_sum + {{32{w.value[63]}}, w.value};
        end
      end
      OP_REMOVE: begin
        if (slot < 0) begin
          r.status = ST_ABSENT;
        end else begin
          cnt_mem[slot] = cnt_mem[slot] - 1;
          if (cnt_mem[slot] == 0) used_mem[slot] = 1'b0;
          held_total = held_total - 1;
          held_sum = held_sum - {{32{w.value[63]}}, w.value};
        end
      end
      OP_REPORT: begin
        if (held_total != 0) begin
          neg = held_sum[95];
          mag = neg ? -held_sum : held_sum;
          quo = mag / {64'd0, held_total};
          m64 = quo[63:0];
          avg_b = (neg ? -m64 : m64) ^ SIGN_BIT;
          have = 1'b0;
          best_d = '0;
          best_k = '0;
          best_c = '0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (used_mem[i]) begin
              d = ((key_mem[i] ^ SIGN_BIT) > avg_b) ? (key_mem[i] ^ SIGN_BIT) - avg_b
                                                     : avg_b - (key_mem[i] ^ SIGN_BIT);
              if (!have || cnt_mem[i] > best_c) begin
                have = 1'b1;
                best_k = key_mem[i];
                best_c = cnt_mem[i];
                best_d = d;
              end else if (cnt_mem[i] == best_c) begin
                if (d < best_d || (d == best_d && abs64(key_mem[i]) < abs64(best_k))) begin
                  best_k = key_mem[i];
                  best_d = d;
                end
              end
            end
          end
          r.mode_value = best_k;
          r.mode_count = best_c;
        end
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++) used_mem[i] = 1'b0;
        held_total = '0;
        held_sum = '0;
      end
    endcase
    r.is_empty = (held_total == 0);
    if (w.op == OP_REPORT) reports_seen++;
    if (r.status == ST_FULL) fulls_seen++;
    if (r.status == ST_ABSENT) absents_seen++;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t mismatch on %s: got %h want %h", $realtime, field, got, want);
    errors++;
  endtask

  // send one word, wait for the handshake, then maybe idle
  task automatic send_word(op_t op, logic [63:0] value, bit typed, out_word_t res);
    in_word_t  w;
    out_word_t p;
    w.op = op;
    w.value = value;
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    p = compute_mode(w);
    mode_q.push_back(typed ? res : p);
    words_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  function automatic out_word_t mk_res(logic [63:0] mv, logic [31:0] mc, logic e, status_t s);
    out_word_t r;
    r.mode_value = mv;
    r.mode_count = mc;
    r.is_empty = e;
    r.status = s;
    return r;
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = MAX_VAL;
      1: v = MIN_VAL;
      2: v = {$urandom, $urandom};
      3, 4: v = 64'($signed($urandom_range(0, 16)) - 8);
      5: v = ($urandom_range(0, 1)) ? MAX_VAL - 1 : MIN_VAL + 1;
      default: v = hot_vals[$urandom_range(0, 7)];
    endcase
    return v;
  endfunction

  // result side stalls in bursts
  int ready_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ch.ready <= 1'b0;
      ready_left = $urandom_range(1, 14);
    end else begin
      out_ch.ready <= 1'b1;
      ready_left = $urandom_range(1, 30);
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (mode_q.size() == 0) begin
        $display("%0t result word with nothing expected", $realtime);
        errors++;
      end else begin
        e = mode_q.pop_front();
        if (out_ch.data.mode_value !== e.mode_value)
          report_mismatch("mode_value", out_ch.data.mode_value, e.mode_value);
        if (out_ch.data.mode_count !== e.mode_count)
          report_mismatch("mode_count", 64'(out_ch.data.mode_count), 64'(e.mode_count));
        if (out_ch.data.is_empty !== e.is_empty)
          report_mismatch("is_empty", 64'(out_ch.data.is_empty), 64'(e.is_empty));
        if (out_ch.data.status !== e.status)
          report_mismatch("status", 64'(out_ch.data.status), 64'(e.status));
      end
    end
  end

  initial begin
    #20ms;
    $display("running_mode_with_tiebreak verification failed");
    $finish;
  end

  stim_row_t table_rows[$];
  out_word_t nores;

  initial begin
    int op_pick;
    int wait_cycles;
    logic [63:0] base;
    nores = '0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      used_mem[i] = 1'b0;
      key_mem[i] = '0;
      cnt_mem[i] = '0;
    end
    held_total = '0;
    held_sum = '0;
    for (int i = 0; i < 8; i++) hot_vals[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows: typed results only where obvious
    table_rows = '{
      '{OP_REPORT, 64'd0,   1'b1, mk_res(64'd0, 32'd0, 1'b1, ST_OK)},
      '{OP_REMOVE, 64'd7,   1'b1, mk_res(64'd0, 32'd0, 1'b1, ST_ABSENT)},
      '{OP_ADD,    MAX_VAL, 1'b1, mk_res(64'd0, 32'd0, 1'b0, ST_OK)},
      '{OP_REPORT, 64'd0,   1'b1, mk_res(MAX_VAL, 32'd1, 1'b0, ST_OK)},
      '{OP_ADD,    MIN_VAL, 1'b1, mk_res(64'd0, 32'd0, 1'b0, ST_OK)},
      '{OP_REPORT, 64'd0,   1'b0, nores},
      '{OP_ADD,    MIN_VAL, 1'b0, nores},
      '{OP_REPORT, 64'd0,   1'b0, nores},
      '{OP_REMOVE, MIN_VAL, 1'b0, nores},
      '{OP_REMOVE, MIN_VAL, 1'b0, nores},
      '{OP_REMOVE, MIN_VAL, 1'b1, mk_res(64'd0, 32'd0, 1'b0, ST_ABSENT)},
      '{OP_REMOVE, MAX_VAL, 1'b1, mk_res(64'd0, 32'd0, 1'b1, ST_OK)},
      // 5 and -5 tie on distance and magnitude around 0: lowest slot wins
      '{OP_ADD,    64'd5,   1'b0, nores},
      '{OP_ADD,    -64'd5,  1'b0, nores},
      '{OP_REPORT, 64'd0,   1'b1, mk_res(64'd5, 32'd1, 1'b0, ST_OK)},
      '{OP_ADD,    64'd1,   1'b0, nores},
      '{OP_ADD,    -64'd2,  1'b0, nores},
      '{OP_REPORT, {64{1'b1}}, 1'b0, nores},
      '{OP_REMOVE, 64'd5,   1'b0, nores},
      '{OP_ADD,    64'd5,   1'b0, nores},
      '{OP_REPORT, 64'd0,   1'b0, nores},
      '{OP_CLEAR,  {64{1'b1}}, 1'b1, mk_res(64'd0, 32'd0, 1'b1, ST_OK)},
      '{OP_REPORT, 64'd0,   1'b1, mk_res(64'd0, 32'd0, 1'b1, ST_OK)}
    };
    foreach (table_rows[i])
      send_word(table_rows[i].op, table_rows[i].value, table_rows[i].typed, table_rows[i].res);

    // fill every slot, then push past the end of the table
    send_word(OP_CLEAR, '0, 1'b0, nores);
    base = {$urandom, $urandom};
    for (int i = 0; i < ENTRIES; i++) send_word(OP_ADD, base + i, 1'b0, nores);
    send_word(OP_ADD, base - 1, 1'b0, nores);
    send_word(OP_ADD, base + 3, 1'b0, nores);
    send_word(OP_REPORT, '0, 1'b0, nores);
    send_word(OP_REMOVE, base + 9, 1'b0, nores);
    send_word(OP_ADD, base - 1, 1'b0, nores);
    send_word(OP_REPORT, '0, 1'b0, nores);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      if ($urandom_range(0, 40) == 0) hot_vals[$urandom_range(0, 7)] = {$urandom, $urandom};
      op_pick = $urandom_range(0, 99);
      if (op_pick < 50) send_word(OP_ADD, pick_value(), 1'b0, nores);
      else if (op_pick < 72) send_word(OP_REMOVE, pick_value(), 1'b0, nores);
      else if (op_pick < 98) send_word(OP_REPORT, {$urandom, $urandom}, 1'b0, nores);
      else send_word(OP_CLEAR, {$urandom, $urandom}, 1'b0, nores);
    end
    in_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (mode_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (400) @(posedge clk);
    $display("sent %0d words: %0d reports, %0d full-table drops, %0d absent removes",
             words_sent, reports_seen, fulls_seen, absents_seen);
    if (errors == 0 && mode_q.size() == 0) begin
      $display("running_mode_with_tiebreak verification clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, mode_q.size());
      $display("running_mode_with_tiebreak verification failed");
    end
    $finish;
  end
endmodule
